### rtl/core/prc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_pkg
// Types, codes and reset values shared by the precharge relay controller.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int BusW  = 20;
  localparam int RatW  = 16;
  localparam int ProdW = BusW + RatW;
  localparam int TmrW  = 16;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_OFF         = 3'd0,
    ST_PRECHARGING = 3'd1,
    ST_PRECHARGED  = 3'd2,
    ST_ENABLED     = 3'd3,
    ST_TIMEOUT     = 3'd4,
    ST_NOLOAD      = 3'd5,
    ST_INIT        = 3'd7
  } ctrl_state_t;

  typedef enum logic [2:0] {
    REG_MODE_FLAGS      = 3'd0,
    REG_PRECHARGE_RATIO = 3'd1,
    REG_PRELOAD_RATIO   = 3'd2,
    REG_TIMEOUT_MS      = 3'd3,
    REG_OVERLAP_MS      = 3'd4,
    REG_RETRY_MS        = 3'd5,
    REG_LOAD_DETECT_MS  = 3'd6
  } cfg_reg_t;

  // bit 0 is the main relay
  typedef struct packed {
    logic det;
    logic err;
    logic preact;
    logic loaden;
    logic pre;
    logic main;
  } out_flags_t;

  localparam logic [2:0]      MODE_RST    = 3'd3;
  localparam logic [RatW-1:0] PC_RAT_RST  = 16'd58982;
  localparam logic [RatW-1:0] PL_RAT_RST  = 16'd6554;
  localparam logic [TmrW-1:0] TIMEOUT_RST = 16'd300;
  localparam logic [TmrW-1:0] OVERLAP_RST = 16'd100;
  localparam logic [TmrW-1:0] RETRY_RST   = 16'd0;
  localparam logic [TmrW-1:0] LOADDET_RST = 16'd50;

endpackage
`default_nettype wire

### rtl/core/prc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface prc_item_if;
  import prc_pkg::*;
  logic            valid;
  logic            ready;
  logic            op;
  logic            relay_desired;
  logic [BusW-1:0] bus_mv;
  logic [BusW-1:0] battery_mv;

  modport source (output valid, op, relay_desired, bus_mv, battery_mv, input ready);
  modport sink   (input valid, op, relay_desired, bus_mv, battery_mv, output ready);
endinterface

interface prc_result_if;
  import prc_pkg::*;
  logic            valid;
  logic            ready;
  logic [2:0]      ctrl_state;
  logic            main_relay;
  logic            precharge_relay;
  logic            load_enabled;
  logic            precharge_active;
  logic            precharge_error;
  logic            load_detected;
  logic [TmrW-1:0] precharge_duration_ms;

  modport source (output valid, ctrl_state, main_relay, precharge_relay, load_enabled,
                  precharge_active, precharge_error, load_detected,
                  precharge_duration_ms, input ready);
  modport sink   (input valid, ctrl_state, main_relay, precharge_relay, load_enabled,
                  precharge_active, precharge_error, load_detected,
                  precharge_duration_ms, output ready);
endinterface
`default_nettype wire

### rtl/core/precharge_relay_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// precharge_relay_controller_top
// Precharge sequencer for a main/precharge relay pair, driven by voltage
// sample words and 1 ms tick words, with an APB register port.
// ----------------------------------------------------------------------------
// Result path: an input word and its ratio products are registered in
//   stage 1; the state/result register loads from stage 1 once it is free.
// Throughput: one word per cycle unless the result channel stalls; the
//   result register holds the state itself.
// Reset (rst, synchronous): channel empty, state off, entry actions pending,
//   timers and flags cleared, registers at their reset values.
module precharge_relay_controller_top (
  input  wire logic                     clk,
  input  wire logic                     rst,
  prc_item_if.sink                      items,
  prc_result_if.source                  results,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [prc_pkg::AddrW-1:0] paddr,
  input  wire logic [prc_pkg::DataW-1:0] pwdata,
  output logic      [prc_pkg::DataW-1:0] prdata,
  output logic                          pready
);
  import prc_pkg::*;

  // configuration
  logic [2:0]      mode_flags;
  logic [RatW-1:0] precharge_ratio;
  logic [RatW-1:0] preload_ratio;
  logic [TmrW-1:0] precharge_timeout_ms;
  logic [TmrW-1:0] overlap_ms;
  logic [TmrW-1:0] retry_ms;
  logic [TmrW-1:0] load_detect_ms;

  logic     cfg_wr;
  cfg_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags           <= MODE_RST;
      precharge_ratio      <= PC_RAT_RST;
      preload_ratio        <= PL_RAT_RST;
      precharge_timeout_ms <= TIMEOUT_RST;
      overlap_ms           <= OVERLAP_RST;
      retry_ms             <= RETRY_RST;
      load_detect_ms       <= LOADDET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE_FLAGS:      mode_flags           <= pwdata[2:0];
        REG_PRECHARGE_RATIO: precharge_ratio      <= pwdata[RatW-1:0];
        REG_PRELOAD_RATIO:   preload_ratio        <= pwdata[RatW-1:0];
        REG_TIMEOUT_MS:      precharge_timeout_ms <= pwdata[TmrW-1:0];
        REG_OVERLAP_MS:      overlap_ms           <= pwdata[TmrW-1:0];
        REG_RETRY_MS:        retry_ms             <= pwdata[TmrW-1:0];
        REG_LOAD_DETECT_MS:  load_detect_ms       <= pwdata[TmrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE_FLAGS:      prdata = {29'd0, mode_flags};
      REG_PRECHARGE_RATIO: prdata = {16'd0, precharge_ratio};
      REG_PRELOAD_RATIO:   prdata = {16'd0, preload_ratio};
      REG_TIMEOUT_MS:      prdata = {16'd0, precharge_timeout_ms};
      REG_OVERLAP_MS:      prdata = {16'd0, overlap_ms};
      REG_RETRY_MS:        prdata = {16'd0, retry_ms};
      REG_LOAD_DETECT_MS:  prdata = {16'd0, load_detect_ms};
      default:             prdata = '0;
    endcase
  end

  // stage 1: input word and ratio products
  logic             s1_valid;
  logic             s1_op;
  logic             s1_req;
  logic [BusW-1:0]  s1_bus;
  logic [ProdW-1:0] s1_pc_lim;
  logic [ProdW-1:0] s1_pl_lim;
  logic             out_valid;
  logic             advance;

  assign advance     = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_op     <= items.op;
      s1_req    <= items.relay_desired;
      s1_bus    <= items.bus_mv;
      s1_pc_lim <= ProdW'(items.battery_mv) * ProdW'(precharge_ratio);
      s1_pl_lim <= ProdW'(items.battery_mv) * ProdW'(preload_ratio);
    end
  end

  // stage 2: controller state, which is also the result word
  ctrl_state_t     state, state_next;
  ctrl_state_t     applied, applied_next;
  logic            last_req, last_req_next;
  logic            bus_pre, bus_pre_next;
  logic [TmrW-1:0] phase_tmr, phase_tmr_next;
  logic [TmrW-1:0] pre_tmr, pre_tmr_next;
  out_flags_t      flags, flags_next;
  logic [TmrW-1:0] duration, duration_next;
  logic [ProdW-1:0] bus_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= ST_OFF;
      applied   <= ST_INIT;
      last_req  <= 1'b0;
      bus_pre   <= 1'b0;
      phase_tmr <= '0;
      pre_tmr   <= '0;
      flags     <= '0;
      duration  <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
        applied   <= applied_next;
        last_req  <= last_req_next;
        bus_pre   <= bus_pre_next;
        phase_tmr <= phase_tmr_next;
        pre_tmr   <= pre_tmr_next;
        flags     <= flags_next;
        duration  <= duration_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    applied_next   = applied;
    last_req_next  = last_req;
    bus_pre_next   = bus_pre;
    phase_tmr_next = phase_tmr;
    pre_tmr_next   = pre_tmr;
    flags_next     = flags;
    duration_next  = duration;
    bus_s          = {s1_bus, {RatW{1'b0}}};

    if (s1_op == OP_TICK) begin
      if (phase_tmr != {TmrW{1'b1}}) phase_tmr_next = phase_tmr + 1'b1;
      if (pre_tmr != {TmrW{1'b1}})   pre_tmr_next   = pre_tmr + 1'b1;

      // entry actions, once per state change
      if (state != applied) begin
        unique case (state)
          ST_OFF: begin
            flags_next = '0;
          end
          ST_PRECHARGING: begin
            flags_next        = '0;
            flags_next.pre    = 1'b1;
            flags_next.preact = 1'b1;
            phase_tmr_next    = '0;
            pre_tmr_next      = '0;
          end
          ST_PRECHARGED: begin
            phase_tmr_next    = '0;
            duration_next     = pre_tmr_next;
            flags_next        = '0;
            flags_next.main   = 1'b1;
            flags_next.pre    = 1'b1;
            flags_next.loaden = 1'b1;
            flags_next.preact = 1'b1;
            flags_next.det    = (pre_tmr_next >= load_detect_ms) || bus_pre;
          end
          ST_TIMEOUT, ST_NOLOAD: begin
            flags_next     = '0;
            flags_next.err = 1'b1;
            phase_tmr_next = '0;
          end
          ST_ENABLED: begin
            flags_next        = '0;
            flags_next.main   = 1'b1;
            flags_next.loaden = 1'b1;
            flags_next.det    = flags.det;
          end
          default: begin
            state_next     = ST_OFF;
            flags_next.det = 1'b0;
          end
        endcase
        applied_next = state_next;
      end

      // waits: each fire restarts the phase timer
      if (state_next == ST_PRECHARGING && phase_tmr_next >= precharge_timeout_ms) begin
        phase_tmr_next = '0;
        state_next     = ST_TIMEOUT;
      end
      if (state_next == ST_PRECHARGED && phase_tmr_next >= overlap_ms) begin
        phase_tmr_next = '0;
        state_next     = (flags_next.det || !mode_flags[2]) ? ST_ENABLED : ST_NOLOAD;
      end
      if ((state_next == ST_TIMEOUT || state_next == ST_NOLOAD) &&
          phase_tmr_next >= retry_ms) begin
        phase_tmr_next = '0;
        if (retry_ms != '0) state_next = mode_flags[1] ? ST_PRECHARGING : ST_ENABLED;
      end
    end else begin
      if (s1_req != last_req) begin
        if (s1_req && mode_flags[0]) begin
          if (mode_flags[1]) begin
            state_next   = ST_PRECHARGING;
            bus_pre_next = bus_s > s1_pl_lim;
          end else begin
            state_next = ST_ENABLED;
          end
        end else begin
          state_next = ST_OFF;
        end
        last_req_next = s1_req;
      end
      if (state_next == ST_PRECHARGING && bus_s >= s1_pc_lim) state_next = ST_PRECHARGED;
      if (state_next == ST_ENABLED && bus_s <= s1_pc_lim && mode_flags[1]) begin
        state_next = ST_TIMEOUT;
      end
    end
  end

  assign results.valid                 = out_valid;
  assign results.ctrl_state            = state;
  assign results.main_relay            = flags.main;
  assign results.precharge_relay       = flags.pre;
  assign results.load_enabled          = flags.loaden;
  assign results.precharge_active      = flags.preact;
  assign results.precharge_error       = flags.err;
  assign results.load_detected         = flags.det;
  assign results.precharge_duration_ms = duration;

endmodule
`default_nettype wire

### rtl/core/prc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks on the result channel of the precharge relay controller.
// ----------------------------------------------------------------------------
module prc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [2:0] res_state,
  input wire logic       res_main,
  input wire logic       res_pre,
  input wire logic       res_loaden,
  input wire logic       res_preact,
  input wire logic       res_err,
  input wire logic       res_det
);
  import prc_pkg::*;

  // relay drive and its status flag are always set together
  a_main_loaden: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_main == res_loaden)
    else $error("main relay and load enabled disagree");

  a_pre_preact: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_pre == res_preact)
    else $error("precharge relay and precharge active disagree");

  // an error word drives no relay
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_err |-> !res_main && !res_pre && !res_det)
    else $error("error flag with relay drive");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_state))
    else $error("stalled result word changed");

endmodule

bind precharge_relay_controller_top prc_checker u_prc_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_state  (results.ctrl_state),
  .res_main   (results.main_relay),
  .res_pre    (results.precharge_relay),
  .res_loaden (results.load_enabled),
  .res_preact (results.precharge_active),
  .res_err    (results.precharge_error),
  .res_det    (results.load_detected)
);
`default_nettype wire
